### rtl/core/bpa_pkg.sv
// Shared constants, request and status codes, and map word helpers for the page allocator.
package bpa_pkg;

    // Field widths
    localparam int PAGE_W     = 9;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_LAST_OS = 1'b0;

    // Default map depth in words
    localparam int MAP_WORDS_DEF = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // Lowest clear bit of a map word (word assumed not all ones)
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // Used bits of the map word starting at page base for pages 0..last_os
    function automatic logic [WORD_BITS-1:0] init_mask(input logic [PAGE_W-1:0] last_os,
                                                       input logic [31:0] base);
        logic [31:0] last_ext;
        logic [31:0] off;
        logic [WORD_BITS-1:0] mask;
        last_ext = {{(32-PAGE_W){1'b0}}, last_os};
        off      = last_ext - base;
        if (last_ext < base)
        begin
            mask = '0;
        end
        else if (off >= 32'(WORD_BITS - 1))
        begin
            mask = '1;
        end
        else
        begin
            mask = ~({WORD_BITS{1'b1}} << 1 << off[BIT_W-1:0]);
        end
        return mask;
    endfunction

endpackage

### rtl/core/bpa_map_ram.sv
// Used-page map storage: one write port, one registered read port.
module bpa_map_ram #(
    parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF,
    parameter int WORD_W    = 4
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [WORD_W-1:0]              wr_addr,
    input  logic [bpa_pkg::WORD_BITS-1:0]  wr_data,
    input  logic [WORD_W-1:0]              rd_addr,
    output logic [bpa_pkg::WORD_BITS-1:0]  rd_data
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/bpa_cfg_regs.sv
// APB-style configuration register holding the last operating-system page.
module bpa_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [bpa_pkg::PAGE_W-1:0]      last_os_page
);
    import bpa_pkg::*;

    logic [PAGE_W-1:0] last_os_reg;
    logic [PAGE_W-1:0] last_os_next;
    logic              reg_sel;
    logic              wr_beat;

    // Register index is the word address
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_LAST_OS);
    assign wr_beat = psel && penable && pwrite;

    always_comb
    begin
        last_os_next = last_os_reg;
        if (wr_beat && reg_sel)
        begin
            last_os_next = pwdata[PAGE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_os_reg <= '0;
        end
        else
        begin
            last_os_reg <= last_os_next;
        end
    end

    // Read data
    assign prdata       = reg_sel ? {{(APB_DATA_W-PAGE_W){1'b0}}, last_os_reg} : '0;
    assign pready       = 1'b1;
    assign last_os_page = last_os_reg;

endmodule

### rtl/core/bpa_ctrl.sv
// Request sequencer: map sweep, first-fit word scan and read-modify-write of the map.
module bpa_ctrl #(
    parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF,
    parameter int WORD_W    = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bpa_pkg::REQ_W-1:0]      req_type,
    input  logic [bpa_pkg::PAGE_W-1:0]     page_in,
    input  logic [bpa_pkg::PAGE_W-1:0]     last_os_page,
    output logic                           busy,
    output logic                           done,
    output logic [bpa_pkg::PAGE_W-1:0]     page_out,
    output logic [bpa_pkg::STATUS_W-1:0]   status,
    output logic [WORD_W-1:0]              rd_addr,
    input  logic [bpa_pkg::WORD_BITS-1:0]  rd_data,
    output logic                           wr_en,
    output logic [WORD_W-1:0]              wr_addr,
    output logic [bpa_pkg::WORD_BITS-1:0]  wr_data
);
    import bpa_pkg::*;

    localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLEAR = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FREE  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [WORD_W-1:0]   idx_reg, idx_next;
    logic                zero_reg, zero_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                done_reg, done_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [31:0]         page_ext;
    logic                in_range;
    logic [WORD_W-1:0]   free_word;
    logic                last_idx;
    logic [BIT_W-1:0]    hit_bit;
    logic [31:0]         hit_page;
    logic [31:0]         word_base;

    // Input decode and scan helpers
    assign page_ext  = {{(32-PAGE_W){1'b0}}, page_in};
    assign in_range  = page_ext < 32'(TOTAL_PAGES);
    assign free_word = WORD_W'(page_ext >> BIT_W);
    assign last_idx  = (idx_reg == LAST_WORD);
    assign hit_bit   = first_zero(rd_data);
    assign word_base = 32'(idx_reg) << BIT_W;
    assign hit_page  = word_base | 32'(hit_bit);

    // Map read address: word zero for an allocation, else the free target on accept;
    // the next word while scanning
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = (req_type == REQ_ALLOC) ? '0 : free_word;
            S_SCAN:  rd_addr = idx_reg + WORD_W'(1);
            default: rd_addr = '0;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        zero_next   = zero_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        page_next   = page_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        REQ_INIT:
                        begin
                            state_next = S_CLEAR;
                            idx_next   = '0;
                            zero_next  = 1'b0;
                        end
                        REQ_ALLOC:
                        begin
                            state_next = S_SCAN;
                            idx_next   = '0;
                        end
                        REQ_FREE:
                        begin
                            if (in_range)
                            begin
                                state_next = S_FREE;
                                idx_next   = free_word;
                                bit_next   = page_in[BIT_W-1:0];
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                page_next   = '0;
                                status_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            // unused request code: no change, plain ok
                            done_next   = 1'b1;
                            page_next   = '0;
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                // one word per cycle; reset sweep writes zeros, init writes OS mask
                wr_en   = 1'b1;
                wr_data = zero_reg ? '0 : init_mask(last_os_page, word_base);
                if (last_idx)
                begin
                    state_next = S_IDLE;
                    if (!zero_reg)
                    begin
                        done_next   = 1'b1;
                        page_next   = '0;
                        status_next = ST_OK;
                    end
                end
                else
                begin
                    idx_next = idx_reg + WORD_W'(1);
                end
            end
            S_SCAN:
            begin
                if (rd_data != '1)
                begin
                    wr_en       = 1'b1;
                    wr_data     = rd_data | (WORD_BITS'(1) << hit_bit);
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    page_next   = hit_page[PAGE_W-1:0];
                    status_next = ST_OK;
                end
                else if (last_idx)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    page_next   = '0;
                    status_next = ST_NO_FREE;
                end
                else
                begin
                    idx_next = idx_reg + WORD_W'(1);
                end
            end
            S_FREE:
            begin
                wr_en       = 1'b1;
                wr_data     = rd_data & ~(WORD_BITS'(1) << bit_reg);
                state_next  = S_IDLE;
                done_next   = 1'b1;
                page_next   = '0;
                status_next = ST_OK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            zero_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            zero_reg  <= zero_next;
            done_reg  <= done_next;
        end
    end

    // Result payload and free bit position
    always_ff @(posedge clk)
    begin
        bit_reg    <= bit_next;
        page_reg   <= page_next;
        status_reg <= status_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign page_out = page_reg;
    assign status   = status_reg;

endmodule

### rtl/core/bitmap_page_allocator.sv
// Top level of the first-fit bitmap page allocator.
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+----------------------------
//  request   | start, busy (beat: start & !busy) | req_type, page_in
//  result    | done (one-cycle strobe)           | page_out, status
//  config    | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
//  Result strobe follows the accepting edge: init once all map words are written
//  (one word written per cycle), allocate once the scan finds a clear bit or the
//  last word (one word read and tested per cycle via the single read port), free
//  after a read and write back, out-of-range free or unused code the next cycle.
//  After reset a clearing pass over every map word holds busy high.
//  busy is low exactly when a request beat can be taken; results cannot be stalled.
module bitmap_page_allocator #(
    parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            start,
    input  logic [bpa_pkg::REQ_W-1:0]       req_type,
    input  logic [bpa_pkg::PAGE_W-1:0]      page_in,
    output logic                            busy,
    output logic                            done,
    output logic [bpa_pkg::PAGE_W-1:0]      page_out,
    output logic [bpa_pkg::STATUS_W-1:0]    status
);
    import bpa_pkg::*;

    localparam int WORD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;

    logic [PAGE_W-1:0]    last_os_page;
    logic [WORD_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WORD_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    bpa_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .last_os_page (last_os_page)
    );

    bpa_map_ram #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_W    (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpa_ctrl #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_W    (WORD_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .page_in      (page_in),
        .last_os_page (last_os_page),
        .busy         (busy),
        .done         (done),
        .page_out     (page_out),
        .status       (status),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // Failed or non-allocating results carry page zero
    a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> page_out == '0)
        else $error("non-ok result with nonzero page");

    // Out-of-range free answers in the next cycle with a range status
    a_range_next: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_FREE
            && {{(32-PAGE_W){1'b0}}, page_in} >= 32'(TOTAL_PAGES)
        |=> done && status == ST_RANGE && !busy)
        else $error("out-of-range free not reported at once");

    // An allocation holds the block busy for at least its first scan cycle
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_ALLOC |=> busy && !done)
        else $error("allocation did not enter scan");

    // A result strobe lasts one cycle unless a new beat was taken in between
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done && !(start && !busy) |=> !done)
        else $error("result strobe repeated");

endmodule
